>>> src/ethip_pkg.sv
// Shared constants, types and the ones-complement adder for the Ethernet/IPv4 frame parser.
`default_nettype none

package ethip_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LEN_W = 17;

  typedef logic [OFF_W-1:0] offset_t;

  localparam offset_t OFF_LIMIT    = offset_t'(MAX_FRAME_BYTES);
  localparam offset_t OFF_ETYPE_LO = offset_t'(13);
  localparam offset_t OFF_IHL      = offset_t'(14);
  localparam offset_t OFF_TOS      = offset_t'(15);
  localparam offset_t OFF_TLEN_LO  = offset_t'(17);
  localparam offset_t OFF_ARPOP_LO = offset_t'(21);
  localparam offset_t OFF_TTL      = offset_t'(22);
  localparam offset_t OFF_PROTO    = offset_t'(23);
  localparam offset_t OFF_PSEUDO_LO = offset_t'(27);
  localparam offset_t OFF_PSEUDO_HI = offset_t'(33);

  localparam int ETH_HDR_BYTES    = 14;
  localparam int MIN_IP_HDR_BYTES = 20;
  localparam int PORT_BYTES       = 4;
  localparam int TCP_FLAGS_REL    = 13;

  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

  localparam logic [7:0] IPPROTO_ICMP = 8'h01;
  localparam logic [7:0] IPPROTO_TCP  = 8'h06;
  localparam logic [7:0] IPPROTO_UDP  = 8'h11;

  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_IPV4    = 2'd1,
    KIND_ARP_REQ = 2'd2,
    KIND_ARP_REP = 2'd3
  } frame_kind_t;

  typedef enum logic [1:0] {
    PK_TCP   = 2'd0,
    PK_ICMP  = 2'd1,
    PK_UDP   = 2'd2,
    PK_OTHER = 2'd3
  } proto_kind_t;

  typedef struct packed {
    logic [15:0] ether_kind;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [7:0]  proto_byte;
    logic [7:0]  tos_byte;
    logic [7:0]  ttl_byte;
    logic [15:0] header_sum;
    logic [15:0] segment_sum;
    logic [7:0]  pending_high;
    logic [31:0] port_pair;
    logic [3:0]  flag_bits;
    logic [7:0]  icmp_byte;
    logic [15:0] arp_operation;
  } frame_state_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

>>> src/ethernet_ipv4_frame_parser.sv
// Top level: byte-wide Ethernet/IPv4 frame parser giving one summary beat per frame.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_ready | frame_byte, last_byte
//   out     | out_valid/out_ready | frame_kind, ip_header_bytes, dscp, ecn,
//           |                     | time_to_live, protocol_kind, ip_checksum_ok,
//           |                     | src_port, dst_port, tcp_flags_seen,
//           |                     | tcp_checksum_ok, icmp_kind
//
// One byte beat per cycle while in_ready is high. Each byte updates the frame state on
// acceptance; the last byte copies the state into a summary register, which moves
// into the output register once that register is empty or being read.
// rst clears the frame state and all valid flags. in_ready drops only while a
// summary waits in both the summary and output registers and out_ready is low.
`default_nettype none

module ethernet_ipv4_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       frame_kind,
  output logic [5:0]       ip_header_bytes,
  output logic [5:0]       dscp,
  output logic [1:0]       ecn,
  output logic [7:0]       time_to_live,
  output logic [1:0]       protocol_kind,
  output logic             ip_checksum_ok,
  output logic [15:0]      src_port,
  output logic [15:0]      dst_port,
  output logic [3:0]       tcp_flags_seen,
  output logic             tcp_checksum_ok,
  output logic [7:0]       icmp_kind
);
  import ethip_pkg::*;

  offset_t      byte_offset, byte_offset_next;
  frame_state_t st, st_next;
  logic         accept;

  logic         snap_valid;
  logic         snap_go;
  frame_state_t snap;
  offset_t      snap_count;

  // byte absorb
  logic [3:0]       hw_new;
  logic [15:0]      tl_new;
  logic [5:0]       hl;
  logic [6:0]       seg;
  logic [LEN_W-1:0] seg_end;
  logic [LEN_W-1:0] o_len;
  offset_t          rel;
  logic             hdr_ok;
  logic             in_seg;
  logic             odd;
  logic [15:0]      word;
  logic             hsum_add;
  logic             pseudo_add;
  logic             tseg_add;
  logic [15:0]      seg_word;

  assign accept   = in_valid && in_ready;
  assign snap_go  = snap_valid && (!out_valid || out_ready);
  assign in_ready = !snap_valid || !out_valid || out_ready;

  assign hw_new  = (byte_offset == OFF_IHL) ? frame_byte[3:0] : st.header_words;
  assign tl_new  = (byte_offset == OFF_TLEN_LO) ? {st.pending_high, frame_byte}
                                                : st.total_length;
  assign hl      = {hw_new, 2'b00};
  assign hdr_ok  = hl >= 6'(MIN_IP_HDR_BYTES);
  assign seg     = 7'(ETH_HDR_BYTES) + 7'(hl);
  assign seg_end = LEN_W'(ETH_HDR_BYTES) + LEN_W'(tl_new);
  assign o_len   = LEN_W'(byte_offset);
  assign rel     = byte_offset - offset_t'(seg);
  assign in_seg  = hdr_ok && (byte_offset >= offset_t'(seg));
  assign odd     = byte_offset[0];
  assign word    = {st.pending_high, frame_byte};

  assign hsum_add   = odd && (byte_offset >= OFF_TOS) && (o_len < LEN_W'(seg));
  assign pseudo_add = odd && (byte_offset >= OFF_PSEUDO_LO) && (byte_offset <= OFF_PSEUDO_HI);
  assign tseg_add   = odd && hdr_ok && (o_len >= LEN_W'(seg) + LEN_W'(1)) &&
                      (o_len <= seg_end);
  assign seg_word   = (tseg_add && !(o_len < seg_end)) ? {st.pending_high, 8'h00} : word;

  always_comb begin
    st_next          = st;
    byte_offset_next = byte_offset;
    if (byte_offset < OFF_LIMIT) begin
      byte_offset_next    = byte_offset + offset_t'(1);
      st_next.header_words = hw_new;
      st_next.total_length = tl_new;
      unique case (byte_offset)
        OFF_ETYPE_LO: st_next.ether_kind    = word;
        OFF_TOS:      st_next.tos_byte      = frame_byte;
        OFF_ARPOP_LO: st_next.arp_operation = word;
        OFF_TTL:      st_next.ttl_byte      = frame_byte;
        OFF_PROTO:    st_next.proto_byte    = frame_byte;
        default: ;
      endcase
      if (in_seg) begin
        if (rel < offset_t'(PORT_BYTES)) begin
          st_next.port_pair = {st.port_pair[23:0], frame_byte};
        end
        if (rel == '0) begin
          st_next.icmp_byte = frame_byte;
        end
        if (rel == offset_t'(TCP_FLAGS_REL)) begin
          st_next.flag_bits = {frame_byte[4], frame_byte[0], frame_byte[2], frame_byte[1]};
        end
      end
      if (odd) begin
        if (hsum_add) begin
          st_next.header_sum = oc_add(st.header_sum, word);
        end
        if (pseudo_add || tseg_add) begin
          st_next.segment_sum = oc_add(st.segment_sum, seg_word);
        end
      end else begin
        st_next.pending_high = frame_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      byte_offset <= '0;
    end else if (accept) begin
      if (last_byte) begin
        st          <= '0;
        byte_offset <= '0;
      end else begin
        st          <= st_next;
        byte_offset <= byte_offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_go) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap       <= st_next;
      snap_count <= byte_offset_next;
    end
  end

  // summary
  frame_kind_t      f_kind;
  proto_kind_t      f_pk;
  logic [5:0]       f_hl;
  logic             f_hdr_ok;
  logic [LEN_W-1:0] f_cnt;
  logic [LEN_W-1:0] f_end;
  logic             f_ipok;
  logic             f_tcp_len_ok;
  logic [15:0]      f_pad;
  logic [15:0]      f_seglen;
  logic [17:0]      f_sum;
  logic [16:0]      f_fold1;
  logic [15:0]      f_fold2;
  logic             f_tcpok;
  logic             f_ip;

  assign f_hl     = {snap.header_words, 2'b00};
  assign f_hdr_ok = f_hl >= 6'(MIN_IP_HDR_BYTES);
  assign f_cnt    = LEN_W'(snap_count);
  assign f_end    = LEN_W'(ETH_HDR_BYTES) + LEN_W'(snap.total_length);
  assign f_ip     = f_kind == KIND_IPV4;

  always_comb begin
    priority if (snap.ether_kind == ETYPE_IPV4) begin
      f_kind = KIND_IPV4;
    end else if (snap.ether_kind == ETYPE_ARP) begin
      f_kind = (snap.arp_operation == ARP_OP_REQUEST) ? KIND_ARP_REQ : KIND_ARP_REP;
    end else begin
      f_kind = KIND_OTHER;
    end
  end

  always_comb begin
    priority if (snap.proto_byte == IPPROTO_TCP) begin
      f_pk = PK_TCP;
    end else if (snap.proto_byte == IPPROTO_ICMP) begin
      f_pk = PK_ICMP;
    end else if (snap.proto_byte == IPPROTO_UDP) begin
      f_pk = PK_UDP;
    end else begin
      f_pk = PK_OTHER;
    end
  end

  assign f_ipok = f_hdr_ok && (f_cnt >= LEN_W'(ETH_HDR_BYTES) + LEN_W'(f_hl)) &&
                  (snap.header_sum == 16'hFFFF);

  assign f_tcp_len_ok = (snap.total_length >= 16'(f_hl)) && (f_cnt >= f_end);
  assign f_pad    = (snap.total_length[0] && (f_cnt == f_end)) ? {snap.pending_high, 8'h00}
                                                               : 16'h0000;
  assign f_seglen = snap.total_length - 16'(f_hl);
  assign f_sum    = 18'(snap.segment_sum) + 18'(f_pad) + 18'(snap.proto_byte) +
                    18'(f_seglen);
  assign f_fold1  = 17'(f_sum[15:0]) + 17'(f_sum[17:16]);
  assign f_fold2  = f_fold1[15:0] + {15'd0, f_fold1[16]};
  assign f_tcpok  = f_hdr_ok && (f_pk == PK_TCP) && f_tcp_len_ok && (f_fold2 == 16'hFFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_go) begin
      frame_kind      <= f_kind;
      ip_header_bytes <= f_ip ? f_hl : '0;
      dscp            <= f_ip ? snap.tos_byte[7:2] : '0;
      ecn             <= f_ip ? snap.tos_byte[1:0] : '0;
      time_to_live    <= f_ip ? snap.ttl_byte : '0;
      protocol_kind   <= f_ip ? f_pk : PK_TCP;
      ip_checksum_ok  <= f_ip && f_ipok;
      src_port        <= (f_ip && f_hdr_ok && (f_pk == PK_TCP || f_pk == PK_UDP))
                         ? snap.port_pair[31:16] : '0;
      dst_port        <= (f_ip && f_hdr_ok && (f_pk == PK_TCP || f_pk == PK_UDP))
                         ? snap.port_pair[15:0] : '0;
      tcp_flags_seen  <= (f_ip && f_hdr_ok && f_pk == PK_TCP) ? snap.flag_bits : '0;
      tcp_checksum_ok <= f_ip && f_tcpok;
      icmp_kind       <= (f_ip && f_hdr_ok && f_pk == PK_ICMP) ? snap.icmp_byte : '0;
    end
  end

endmodule

`default_nettype wire

>>> src/ethip_checker.sv
// Port-level checker for the frame parser, bound to the top level.
`default_nettype none

module ethip_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  frame_byte,
  input wire logic        last_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  frame_kind,
  input wire logic [5:0]  ip_header_bytes,
  input wire logic [5:0]  dscp,
  input wire logic [1:0]  ecn,
  input wire logic [7:0]  time_to_live,
  input wire logic [1:0]  protocol_kind,
  input wire logic        ip_checksum_ok,
  input wire logic [15:0] src_port,
  input wire logic [15:0] dst_port,
  input wire logic [3:0]  tcp_flags_seen,
  input wire logic        tcp_checksum_ok,
  input wire logic [7:0]  icmp_kind
);
  import ethip_pkg::*;

  // a stalled summary beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_kind) && $stable(src_port) &&
      $stable(tcp_checksum_ok))
    else $error("output beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_non_ip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_IPV4 |->
      ip_header_bytes == '0 && dscp == '0 && ecn == '0 && time_to_live == '0 &&
      !ip_checksum_ok && src_port == '0 && dst_port == '0 && icmp_kind == '0)
    else $error("non-IPv4 summary carries IP fields");

  a_non_tcp: assert property (@(posedge clk) disable iff (rst)
    out_valid && protocol_kind != PK_TCP |-> tcp_flags_seen == '0 && !tcp_checksum_ok)
    else $error("TCP fields set on a non-TCP summary");

  a_short_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && ip_header_bytes < 6'(MIN_IP_HDR_BYTES) |->
      !ip_checksum_ok && src_port == '0 && dst_port == '0 && !tcp_checksum_ok)
    else $error("transport fields set with a short IP header");

endmodule

bind ethernet_ipv4_frame_parser ethip_checker u_ethip_checker (.*);

`default_nettype wire
